>>> sv/http_response_deframer_assert.svh
// assertion macros used by the deframer rtl
`ifndef HTTP_RESPONSE_DEFRAMER_ASSERT_SVH
`define HTTP_RESPONSE_DEFRAMER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define HRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hrd_pkg.sv
// types, character constants and byte classification for the deframer
package hrd_pkg;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
        logic       last_byte;
    } t_item;

    typedef struct packed {
        logic        body_valid;
        logic [7:0]  body_byte;
        logic        status_valid;
        logic [15:0] resp_status;
        logic        message_done;
        logic        parse_error;
        logic        incomplete;
        logic [31:0] consumed_count;
    } t_result;

    // byte with its character classes worked out
    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
        logic       last_byte;
        logic       is_cr;
        logic       is_lf;
        logic       is_ws;
        logic       is_blank;
        logic       is_dig;
        logic       is_hex;
        logic       is_colon;
        logic [3:0] hex_val;
        logic [7:0] lc;
    } t_cls;

    function automatic t_cls classify(logic [7:0] b, logic rs, logic lb);
        t_cls c;
        c.in_byte   = b;
        c.restart   = rs;
        c.last_byte = lb;
        c.is_cr     = (b == CH_CR);
        c.is_lf     = (b == CH_LF);
        c.is_blank  = (b == 8'h20) || (b == 8'h09);
        c.is_ws     = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0d));
        c.is_dig    = (b >= 8'h30) && (b <= 8'h39);
        c.is_colon  = (b == CH_COLON);
        c.lc        = ((b >= 8'h41) && (b <= 8'h5a)) ? (b + 8'h20) : b;
        c.is_hex    = 1'b1;
        c.hex_val   = 4'd0;
        if (c.is_dig) begin
            c.hex_val = 4'(b - 8'h30);
        end else if ((b >= 8'h61) && (b <= 8'h66)) begin
            c.hex_val = 4'(b - 8'h57);
        end else if ((b >= 8'h41) && (b <= 8'h46)) begin
            c.hex_val = 4'(b - 8'h37);
        end else begin
            c.is_hex = 1'b0;
        end
        return c;
    endfunction

    // "content-length"
    function automatic logic [7:0] cl_char(logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0:  r = 8'h63; 5'd1:  r = 8'h6f; 5'd2:  r = 8'h6e; 5'd3:  r = 8'h74;
            5'd4:  r = 8'h65; 5'd5:  r = 8'h6e; 5'd6:  r = 8'h74; 5'd7:  r = 8'h2d;
            5'd8:  r = 8'h6c; 5'd9:  r = 8'h65; 5'd10: r = 8'h6e; 5'd11: r = 8'h67;
            5'd12: r = 8'h74; 5'd13: r = 8'h68;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "transfer-encoding"
    function automatic logic [7:0] te_char(logic [4:0] p);
        logic [7:0] r;
        case (p)
            5'd0:  r = 8'h74; 5'd1:  r = 8'h72; 5'd2:  r = 8'h61; 5'd3:  r = 8'h6e;
            5'd4:  r = 8'h73; 5'd5:  r = 8'h66; 5'd6:  r = 8'h65; 5'd7:  r = 8'h72;
            5'd8:  r = 8'h2d; 5'd9:  r = 8'h65; 5'd10: r = 8'h6e; 5'd11: r = 8'h63;
            5'd12: r = 8'h6f; 5'd13: r = 8'h64; 5'd14: r = 8'h69; 5'd15: r = 8'h6e;
            5'd16: r = 8'h67;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // "chunked"
    function automatic logic [7:0] ck_char(logic [2:0] p);
        logic [7:0] r;
        case (p)
            3'd0: r = 8'h63; 3'd1: r = 8'h68; 3'd2: r = 8'h75; 3'd3: r = 8'h6e;
            3'd4: r = 8'h6b; 3'd5: r = 8'h65; 3'd6: r = 8'h64;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

>>> sv/http_response_deframer.sv
// top level of the http response deframer
// one response byte per transfer on the push side, one result per byte on the pop side.
// sustained rate is one byte per clock: the parser state machine in hrd_back retires
// a byte every cycle the output queue has room. a pushed byte is written into the input
// queue, parsed out of it by hrd_back, and its result is registered in the result queue,
// from which it is shown on the pop side. restart clears parse state ahead of its
// own byte; after message_done or parse_error bytes are counted as ignored (count
// frozen) until restart. content-length wins over chunked coding.
// LENGTH_BITS sets the width of body and chunk lengths.
module http_response_deframer #(
    parameter int LENGTH_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  hrd_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output hrd_pkg::t_result o_result
);
    // front to back queue
    logic          q_full, q_wr, q_empty, q_rd;
    hrd_pkg::t_cls q_din, q_dout;
    // back to output queue
    logic             o_full_int, res_push;
    hrd_pkg::t_result res;

    hrd_front u_front (
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_cls    (q_din)
    );

    hrd_fifo #(.WIDTH($bits(hrd_pkg::t_cls)), .DEPTH(2)) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_din),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (q_dout)
    );

    hrd_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_cls      (q_dout),
        .o_pop      (q_rd),
        .i_out_full (o_full_int),
        .o_push     (res_push),
        .o_result   (res)
    );

    // result queue parts the parser from the consumer
    hrd_fifo #(.WIDTH($bits(hrd_pkg::t_result)), .DEPTH(2)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_data  (res),
        .o_full  (o_full_int),
        .i_rd    (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );
endmodule

>>> sv/hrd_fifo.sv
// small first-word-fall-through queue in flip-flops
module hrd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(wr_ok) - CW'(rd_ok);
        end
    end
endmodule

>>> sv/hrd_front.sv
// front end: takes response bytes and tags their character classes
module hrd_front (
    input  logic          push,
    output logic          full,
    input  hrd_pkg::t_item i_item,
    input  logic          i_q_full,
    output logic          o_q_wr,
    output hrd_pkg::t_cls o_cls
);
    assign full   = i_q_full;
    assign o_q_wr = push && !i_q_full;
    assign o_cls  = hrd_pkg::classify(i_item.in_byte, i_item.restart, i_item.last_byte);
endmodule

>>> sv/hrd_back.sv
// back end: response parse state machine, one classified byte per step
`include "http_response_deframer_assert.svh"
module hrd_back #(
    parameter int LENGTH_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  hrd_pkg::t_cls    i_cls,
    output logic             o_pop,
    input  logic             i_out_full,
    output logic             o_push,
    output hrd_pkg::t_result o_result
);
    localparam int LB = LENGTH_BITS;
    localparam int NW = (LENGTH_BITS > 17) ? LENGTH_BITS : 17;

    typedef enum logic [26:0] {
        P_SL_LEAD  = 27'd1 << 0,  P_SL_VER   = 27'd1 << 1,  P_SL_GAP   = 27'd1 << 2,
        P_SL_CODE  = 27'd1 << 3,  P_SL_REASON= 27'd1 << 4,  P_SL_BAD   = 27'd1 << 5,
        P_H_NAME   = 27'd1 << 6,  P_CL_LEAD  = 27'd1 << 7,  P_CL_DIG   = 27'd1 << 8,
        P_CL_TAIL  = 27'd1 << 9,  P_CL_BAD   = 27'd1 << 10, P_TE_LEAD  = 27'd1 << 11,
        P_TE_MATCH = 27'd1 << 12, P_TE_TRAIL = 27'd1 << 13, P_TE_BAD   = 27'd1 << 14,
        P_H_SKIP   = 27'd1 << 15, P_BODY     = 27'd1 << 16, P_CK_LEAD  = 27'd1 << 17,
        P_CK_DIG   = 27'd1 << 18, P_CK_TAIL  = 27'd1 << 19, P_CK_BAD   = 27'd1 << 20,
        P_CK_DATA  = 27'd1 << 21, P_CK_CR    = 27'd1 << 22, P_CK_LF    = 27'd1 << 23,
        P_TRAILER  = 27'd1 << 24, P_DONE     = 27'd1 << 25, P_ERR      = 27'd1 << 26
    } t_phase;

    typedef struct packed {
        t_phase        phase;
        logic          pend_cr;
        logic [15:0]   status;
        logic [NW-1:0] num;
        logic          dig_seen;
        logic [LB-1:0] len_val;
        logic          len_seen;
        logic          len_ok;
        logic          chunked;
        logic [4:0]    name_pos;
        logic [1:0]    cand;
        logic [2:0]    val_pos;
        logic [LB-1:0] remain;
        logic [31:0]   count;
        logic          f_status;
        logic          f_done;
    } t_st;

    function automatic t_st rst_st();
        t_st s;
        s          = '0;
        s.phase    = P_SL_LEAD;
        s.cand     = 2'b11;
        return s;
    endfunction

    function automatic t_st new_line(t_st s_in);
        t_st s;
        s          = s_in;
        s.phase    = P_H_NAME;
        s.name_pos = '0;
        s.cand     = 2'b11;
        return s;
    endfunction

    function automatic t_st finish(t_st s_in);
        t_st s;
        s        = s_in;
        s.phase  = P_DONE;
        s.f_done = 1'b1;
        return s;
    endfunction

    function automatic t_st line_char(t_st s_in, hrd_pkg::t_cls c);
        t_st             s;
        logic [NW+3:0]   t;
        logic [NW-1:0]   d;
        s = s_in;
        d = NW'(c.hex_val);
        t = ({4'd0, s.num} << 3) + ({4'd0, s.num} << 1) + {4'd0, d};
        case (s.phase)
            P_SL_LEAD: if (!c.is_ws) s.phase = P_SL_VER;
            P_SL_VER:  if (c.is_ws) s.phase = P_SL_GAP;
            P_SL_GAP: begin
                if (c.is_dig) begin
                    s.num   = d;
                    s.phase = P_SL_CODE;
                end else if (!c.is_ws) begin
                    s.phase = P_SL_BAD;
                end
            end
            P_SL_CODE: begin
                if (c.is_dig) begin
                    // saturate just past the legal range
                    s.num = (t > (NW+4)'(65536)) ? NW'(65536) : t[NW-1:0];
                end else begin
                    s.phase = P_SL_REASON;
                end
            end
            P_H_NAME: begin
                if (c.is_colon) begin
                    if (s.cand[0] && s.name_pos == 5'd14) begin
                        s.phase = P_CL_LEAD;
                        s.num   = '0;
                    end else if (s.cand[1] && s.name_pos == 5'd17) begin
                        s.phase   = P_TE_LEAD;
                        s.val_pos = '0;
                    end else begin
                        s.phase = P_H_SKIP;
                    end
                end else begin
                    if (s.name_pos >= 5'd14 || c.lc != hrd_pkg::cl_char(s.name_pos)) begin
                        s.cand[0] = 1'b0;
                    end
                    if (s.name_pos >= 5'd17 || c.lc != hrd_pkg::te_char(s.name_pos)) begin
                        s.cand[1] = 1'b0;
                    end
                    if (s.name_pos < 5'd31) s.name_pos = s.name_pos + 5'd1;
                end
            end
            P_CL_LEAD: begin
                if (c.is_dig) begin
                    s.num   = d;
                    s.phase = P_CL_DIG;
                end else if (!c.is_ws) begin
                    s.phase = P_CL_BAD;
                end
            end
            P_CL_DIG: begin
                if (!c.is_dig) begin
                    s.phase = P_CL_TAIL;
                end else if (t[NW+3:LB] != '0) begin
                    s.phase = P_CL_BAD;
                end else begin
                    s.num = t[NW-1:0];
                end
            end
            P_TE_LEAD, P_TE_MATCH: begin
                if (s.phase == P_TE_LEAD && c.is_blank) begin
                    s.phase = P_TE_LEAD;
                end else if (s.val_pos < 3'd7 && c.in_byte == hrd_pkg::ck_char(s.val_pos)) begin
                    s.phase   = P_TE_MATCH;
                    s.val_pos = s.val_pos + 3'd1;
                end else if (s.val_pos == 3'd7 && c.is_blank) begin
                    s.phase = P_TE_TRAIL;
                end else begin
                    s.phase = P_TE_BAD;
                end
            end
            P_TE_TRAIL: if (!c.is_blank) s.phase = P_TE_BAD;
            P_CK_LEAD: begin
                if (c.is_hex) begin
                    s.num   = d;
                    s.phase = P_CK_DIG;
                end else if (!c.is_ws) begin
                    s.phase = P_CK_BAD;
                end
            end
            P_CK_DIG: begin
                if (!c.is_hex) begin
                    s.phase = P_CK_TAIL;
                end else if (s.num[LB-1:LB-4] != 4'd0) begin
                    s.phase = P_CK_BAD;
                end else begin
                    s.num = NW'({s.num[LB-5:0], c.hex_val});
                end
            end
            P_TRAILER: s.dig_seen = 1'b1;
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_st headers_end(t_st s_in);
        t_st s;
        s = s_in;
        if (s.len_seen) begin
            if (!s.len_ok) begin
                s.phase = P_ERR;
            end else if (s.len_val == '0) begin
                s = finish(s);
            end else begin
                s.remain = s.len_val;
                s.phase  = P_BODY;
            end
        end else if (s.chunked) begin
            s.phase = P_CK_LEAD;
        end else begin
            s = finish(s);
        end
        return s;
    endfunction

    function automatic t_st line_end(t_st s_in);
        t_st s;
        s = s_in;
        case (s.phase)
            P_SL_CODE, P_SL_REASON: begin
                if (s.num > NW'(65535)) begin
                    s.phase = P_ERR;
                end else begin
                    s.status   = s.num[15:0];
                    s.f_status = 1'b1;
                    s          = new_line(s);
                end
            end
            P_SL_LEAD, P_SL_VER, P_SL_GAP, P_SL_BAD, P_CK_LEAD, P_CK_BAD: s.phase = P_ERR;
            P_H_NAME: begin
                if (s.name_pos == '0) s = headers_end(s);
                else s.phase = P_ERR;
            end
            P_CL_LEAD, P_CL_DIG, P_CL_TAIL, P_CL_BAD: begin
                s.len_seen = 1'b1;
                s.len_ok   = (s.phase == P_CL_DIG) || (s.phase == P_CL_TAIL);
                s.len_val  = s.len_ok ? s.num[LB-1:0] : '0;
                s          = new_line(s);
            end
            P_TE_LEAD, P_TE_MATCH, P_TE_TRAIL, P_TE_BAD: begin
                s.chunked = (s.phase == P_TE_MATCH && s.val_pos == 3'd7) ||
                            (s.phase == P_TE_TRAIL);
                s = new_line(s);
            end
            P_H_SKIP: s = new_line(s);
            P_CK_DIG, P_CK_TAIL: begin
                if (s.num == '0) begin
                    s.phase    = P_TRAILER;
                    s.dig_seen = 1'b0;
                end else begin
                    s.remain = s.num[LB-1:0];
                    s.phase  = P_CK_DATA;
                end
            end
            P_TRAILER: begin
                if (!s.dig_seen) s = finish(s);
                s.dig_seen = 1'b0;
            end
            default: ;
        endcase
        return s;
    endfunction

    t_st              r_st, n_st, cur;
    logic             body_v, live;
    hrd_pkg::t_cls    cr_cls;

    assign cr_cls = hrd_pkg::classify(hrd_pkg::CH_CR, 1'b0, 1'b0);
    assign o_pop  = !i_empty && !i_out_full;
    assign o_push = o_pop;

    always_comb begin
        cur        = i_cls.restart ? rst_st() : r_st;
        n_st       = cur;
        n_st.f_status = 1'b0;
        n_st.f_done   = 1'b0;
        body_v     = 1'b0;
        live       = (cur.phase != P_DONE) && (cur.phase != P_ERR);
        if (live) begin
            n_st.count = cur.count + 32'd1;
            if (cur.phase == P_BODY || cur.phase == P_CK_DATA) begin
                body_v      = 1'b1;
                n_st.remain = cur.remain - 1'b1;
                if (n_st.remain == '0) begin
                    if (cur.phase == P_BODY) n_st = finish(n_st);
                    else n_st.phase = P_CK_CR;
                end
            end else if (cur.phase == P_CK_CR) begin
                n_st.phase = i_cls.is_cr ? P_CK_LF : P_ERR;
            end else if (cur.phase == P_CK_LF) begin
                n_st.phase = i_cls.is_lf ? P_CK_LEAD : P_ERR;
            end else if (cur.pend_cr) begin
                if (i_cls.is_lf) begin
                    n_st.pend_cr = 1'b0;
                    n_st         = line_end(n_st);
                end else begin
                    // the held cr was a plain line character
                    n_st = line_char(n_st, cr_cls);
                    if (i_cls.is_cr) begin
                        n_st.pend_cr = 1'b1;
                    end else begin
                        n_st.pend_cr = 1'b0;
                        n_st         = line_char(n_st, i_cls);
                    end
                end
            end else if (i_cls.is_cr) begin
                n_st.pend_cr = 1'b1;
            end else begin
                n_st = line_char(n_st, i_cls);
            end
        end
        o_result.body_valid     = body_v;
        o_result.body_byte      = body_v ? i_cls.in_byte : 8'd0;
        o_result.status_valid   = n_st.f_status;
        o_result.resp_status    = n_st.f_status ? n_st.status : 16'd0;
        o_result.message_done   = n_st.f_done;
        o_result.parse_error    = (n_st.phase == P_ERR);
        o_result.incomplete     = i_cls.last_byte && (n_st.phase != P_DONE) &&
                                  (n_st.phase != P_ERR);
        o_result.consumed_count = n_st.count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rst_st();
        end else if (o_pop) begin
            r_st <= n_st;
        end
    end

    `HRD_ASSERT_NEXT(a_done_state, o_pop && o_result.message_done, r_st.phase == P_DONE, "done without done state")
    `HRD_ASSERT_NEXT(a_err_state, o_pop && o_result.parse_error, r_st.phase == P_ERR, "error flag without error state")
    `HRD_ASSERT_NEXT(a_count_frozen, o_pop && !i_cls.restart && (r_st.phase == P_DONE || r_st.phase == P_ERR), $stable(r_st.count), "count moved after end of response")
    `HRD_ASSERT_NOW(a_body_phase, o_pop && o_result.body_valid, cur.phase == P_BODY || cur.phase == P_CK_DATA, "body byte outside body")
endmodule

>>> dv/tb_top.sv
// self-checking testbench for the http response deframer
module tb_top;

    // parser phases of the predictor
    typedef enum logic [4:0] {
        PH_SL_LEAD, PH_SL_VER, PH_SL_GAP, PH_SL_CODE, PH_SL_REASON, PH_SL_BAD,
        PH_H_NAME, PH_CL_LEAD, PH_CL_DIG, PH_CL_TAIL, PH_CL_BAD,
        PH_TE_LEAD, PH_TE_MATCH, PH_TE_TRAIL, PH_TE_BAD, PH_H_SKIP, PH_BODY,
        PH_CK_LEAD, PH_CK_DIG, PH_CK_TAIL, PH_CK_BAD, PH_CK_DATA, PH_CK_CR,
        PH_CK_LF, PH_TRAILER, PH_DONE, PH_ERR
    } t_phase;

    localparam string CL_WORD = "content-length";
    localparam string TE_WORD = "transfer-encoding";
    localparam string CK_WORD = "chunked";

    logic             i_clk;
    logic             i_rst_n;
    logic             push;
    logic             full;
    hrd_pkg::t_item   i_item;
    logic             empty;
    logic             pop;
    hrd_pkg::t_result o_result;

    http_response_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    // predictor state
    t_phase      ph;
    bit          pend_cr;
    bit [15:0]   status_acc;
    bit [31:0]   num_acc;
    bit          trailer_text;
    bit [31:0]   cl_value;
    bit          cl_seen;
    bit          cl_valid;
    bit          chunked;
    bit [4:0]    name_pos;
    bit [1:0]    name_live;
    bit [2:0]    val_pos;
    bit [31:0]   body_left;
    bit [31:0]   byte_cnt;
    bit          r_body_valid;
    bit          r_status_valid;
    bit          r_done;

    hrd_pkg::t_item   pending_items[$];
    hrd_pkg::t_result expected_results[$];
    int      mismatches;
    int      sent_total;
    int      hold_off;

    function automatic bit ws_char(bit [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic bit blank_char(bit [7:0] c);
        return c == 8'h20 || c == 8'h09;
    endfunction

    function automatic bit dig_char(bit [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic int hex_digit(bit [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic parser_clear();
        ph = PH_SL_LEAD; pend_cr = 0; status_acc = 0; num_acc = 0;
        trailer_text = 0; cl_value = 0; cl_seen = 0; cl_valid = 0; chunked = 0;
        name_pos = 0; name_live = 2'b11; val_pos = 0; body_left = 0; byte_cnt = 0;
    endtask

    task automatic next_header();
        ph = PH_H_NAME; name_pos = 0; name_live = 2'b11;
    endtask

    task automatic take_char(bit [7:0] c);
        bit [7:0] lc;
        int h;
        bit [63:0] wide;
        case (ph)
            PH_SL_LEAD: if (!ws_char(c)) ph = PH_SL_VER;
            PH_SL_VER:  if (ws_char(c)) ph = PH_SL_GAP;
            PH_SL_GAP: begin
                if (dig_char(c)) begin
                    num_acc = c - "0"; ph = PH_SL_CODE;
                end else if (!ws_char(c)) begin
                    ph = PH_SL_BAD;
                end
            end
            PH_SL_CODE: begin
                if (dig_char(c)) begin
                    num_acc = num_acc * 10 + (c - "0");
                    if (num_acc > 65536) num_acc = 65536;
                end else begin
                    ph = PH_SL_REASON;
                end
            end
            PH_H_NAME: begin
                if (c == hrd_pkg::CH_COLON) begin
                    if (name_live[0] && name_pos == 14) begin
                        ph = PH_CL_LEAD; num_acc = 0;
                    end else if (name_live[1] && name_pos == 17) begin
                        ph = PH_TE_LEAD; val_pos = 0;
                    end else begin
                        ph = PH_H_SKIP;
                    end
                end else begin
                    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                    if (name_pos >= 14 || lc != CL_WORD[name_pos]) name_live[0] = 0;
                    if (name_pos >= 17 || lc != TE_WORD[name_pos]) name_live[1] = 0;
                    if (name_pos < 31) name_pos++;
                end
            end
            PH_CL_LEAD: begin
                if (dig_char(c)) begin
                    num_acc = c - "0"; ph = PH_CL_DIG;
                end else if (!ws_char(c)) begin
                    ph = PH_CL_BAD;
                end
            end
            PH_CL_DIG: begin
                if (dig_char(c)) begin
                    wide = 64'(num_acc) * 10 + (c - "0");
                    if (wide > 64'hffff_ffff) ph = PH_CL_BAD;
                    else num_acc = wide[31:0];
                end else begin
                    ph = PH_CL_TAIL;
                end
            end
            PH_TE_LEAD, PH_TE_MATCH: begin
                if (!(ph == PH_TE_LEAD && blank_char(c))) begin
                    ph = PH_TE_MATCH;
                    if (val_pos < 7 && c == CK_WORD[val_pos]) val_pos++;
                    else if (val_pos == 7 && blank_char(c)) ph = PH_TE_TRAIL;
                    else ph = PH_TE_BAD;
                end
            end
            PH_TE_TRAIL: if (!blank_char(c)) ph = PH_TE_BAD;
            PH_CK_LEAD: begin
                h = hex_digit(c);
                if (h >= 0) begin
                    num_acc = h; ph = PH_CK_DIG;
                end else if (!ws_char(c)) begin
                    ph = PH_CK_BAD;
                end
            end
            PH_CK_DIG: begin
                h = hex_digit(c);
                if (h < 0) ph = PH_CK_TAIL;
                else if (num_acc > 32'h0fff_ffff) ph = PH_CK_BAD;
                else num_acc = {num_acc[27:0], 4'(h)};
            end
            PH_TRAILER: trailer_text = 1;
            default: ;
        endcase
    endtask

    task automatic end_of_line();
        case (ph)
            PH_SL_CODE, PH_SL_REASON: begin
                if (num_acc > 65535) begin
                    ph = PH_ERR;
                end else begin
                    status_acc = num_acc[15:0]; r_status_valid = 1; next_header();
                end
            end
            PH_SL_LEAD, PH_SL_VER, PH_SL_GAP, PH_SL_BAD: ph = PH_ERR;
            PH_H_NAME: begin
                if (name_pos != 0) begin
                    ph = PH_ERR;
                end else if (cl_seen) begin
                    if (!cl_valid) ph = PH_ERR;
                    else if (cl_value == 0) begin ph = PH_DONE; r_done = 1; end
                    else begin body_left = cl_value; ph = PH_BODY; end
                end else if (chunked) begin
                    ph = PH_CK_LEAD;
                end else begin
                    ph = PH_DONE; r_done = 1;
                end
            end
            PH_CL_LEAD, PH_CL_DIG, PH_CL_TAIL, PH_CL_BAD: begin
                cl_seen = 1;
                cl_valid = (ph == PH_CL_DIG || ph == PH_CL_TAIL);
                cl_value = cl_valid ? num_acc : 0;
                next_header();
            end
            PH_TE_LEAD, PH_TE_MATCH, PH_TE_TRAIL, PH_TE_BAD: begin
                chunked = (ph == PH_TE_MATCH && val_pos == 7) || ph == PH_TE_TRAIL;
                next_header();
            end
            PH_H_SKIP: next_header();
            PH_CK_DIG, PH_CK_TAIL: begin
                if (num_acc == 0) begin
                    ph = PH_TRAILER; trailer_text = 0;
                end else begin
                    body_left = num_acc; ph = PH_CK_DATA;
                end
            end
            PH_CK_LEAD, PH_CK_BAD: ph = PH_ERR;
            PH_TRAILER: begin
                if (!trailer_text) begin ph = PH_DONE; r_done = 1; end
                trailer_text = 0;
            end
            default: ;
        endcase
    endtask

    // advance the predictor by one byte and queue the result it calls for
    task automatic predict_byte(hrd_pkg::t_item it);
        hrd_pkg::t_result r;
        bit [7:0] c;
        c = it.in_byte;
        if (it.restart) parser_clear();
        r_body_valid = 0; r_status_valid = 0; r_done = 0;
        r = '0;
        if (ph != PH_DONE && ph != PH_ERR) begin
            byte_cnt++;
            if (ph == PH_BODY || ph == PH_CK_DATA) begin
                r_body_valid = 1; r.body_byte = c;
                body_left--;
                if (body_left == 0) begin
                    if (ph == PH_BODY) begin ph = PH_DONE; r_done = 1; end
                    else ph = PH_CK_CR;
                end
            end else if (ph == PH_CK_CR) begin
                ph = (c == hrd_pkg::CH_CR) ? PH_CK_LF : PH_ERR;
            end else if (ph == PH_CK_LF) begin
                ph = (c == hrd_pkg::CH_LF) ? PH_CK_LEAD : PH_ERR;
            end else if (pend_cr) begin
                if (c == hrd_pkg::CH_LF) begin
                    pend_cr = 0; end_of_line();
                end else begin
                    take_char(hrd_pkg::CH_CR);
                    if (c == hrd_pkg::CH_CR) pend_cr = 1;
                    else begin pend_cr = 0; take_char(c); end
                end
            end else if (c == hrd_pkg::CH_CR) begin
                pend_cr = 1;
            end else begin
                take_char(c);
            end
        end
        r.body_valid     = r_body_valid;
        r.status_valid   = r_status_valid;
        r.resp_status    = r_status_valid ? status_acc : 16'd0;
        r.message_done   = r_done;
        r.parse_error    = (ph == PH_ERR);
        r.incomplete     = it.last_byte && ph != PH_DONE && ph != PH_ERR;
        r.consumed_count = byte_cnt;
        expected_results.push_back(r);
    endtask

    // stimulus helpers
    task automatic send_text(string s, bit first = 0);
        hrd_pkg::t_item it;
        for (int k = 0; k < s.len(); k++) begin
            it.in_byte = s[k];
            it.restart = first && k == 0;
            it.last_byte = ($urandom_range(0, 15) == 0);
            pending_items.push_back(it);
            sent_total++;
        end
    endtask

    task automatic send_noise(int n);
        hrd_pkg::t_item it;
        for (int k = 0; k < n; k++) begin
            it.in_byte = $urandom_range(0, 255);
            it.restart = ($urandom_range(0, 19) == 0);
            it.last_byte = $urandom_range(0, 1);
            pending_items.push_back(it);
            sent_total++;
        end
    endtask

    function automatic string rand_case(string s);
        string o;
        o = s;
        for (int k = 0; k < o.len(); k++)
            if (o[k] >= "a" && o[k] <= "z" && $urandom_range(0, 1)) o[k] = o[k] - 8'd32;
        return o;
    endfunction

    function automatic string rand_body(int n);
        string o;
        o = "";
        for (int k = 0; k < n; k++) o = {o, string'(8'($urandom_range(0, 255)))};
        return o;
    endfunction

    // one random response, mostly well formed
    task automatic send_response();
        string s, body;
        int n, sel;
        s = $sformatf("HTTP/1.1 %0d OK\r\n", $urandom_range(0, 3) == 0 ?
                      $urandom_range(0, 99999) : $urandom_range(100, 599));
        sel = $urandom_range(0, 5);
        if ($urandom_range(0, 2) == 0) s = {s, "X-Other: a\r\n"};
        if (sel < 3) begin
            n = $urandom_range(0, 12);
            s = {s, rand_case("content-length"), ": ", $sformatf("%0d", n), "\r\n\r\n",
                 rand_body(n)};
        end else if (sel < 5) begin
            s = {s, rand_case("transfer-encoding"), ":  chunked \r\n\r\n"};
            for (int k = $urandom_range(0, 2); k > 0; k--) begin
                n = $urandom_range(1, 10);
                s = {s, $sformatf("%0x;x\r\n", n), rand_body(n), "\r\n"};
            end
            s = {s, "0\r\n", $urandom_range(0, 1) ? "T: 1\r\n" : "", "\r\n"};
        end else begin
            s = {s, "\r\n"};
        end
        // break a few with a flipped byte
        if ($urandom_range(0, 7) == 0) s[$urandom_range(0, s.len() - 1)] = $urandom_range(0, 255);
        send_text(s, 1);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // sender: bursts with gaps, nonblocking drive at the edge
    int burst_left, gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 0; i_item <= '0; burst_left <= 0; gap_left <= 0;
        end else begin
            if (push && !full) begin
                predict_byte(i_item);
                void'(pending_items.pop_front());
            end
            if (push && full) begin
                // offered transfer waits, item held as it is
                push <= 1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                push <= 0;
            end else if (pending_items.size() == 0) begin
                push <= 0;
            end else if (burst_left <= 0) begin
                push <= 0;
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                push <= 1;
                i_item <= pending_items[0];
                burst_left <= burst_left - 1;
            end
        end
    end

    // receiver stall pattern plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pop <= 0;
        end else begin
            pop <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0 &&
                   expected_results.size() > 20);
        end
    end

    // monitor: compare each popped result against the oldest expectation
    always @(posedge i_clk) begin
        hrd_pkg::t_result e;
        if (i_rst_n && pop && !empty) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: %p", o_result);
                mismatches++;
            end else begin
                e = expected_results.pop_front();
                if (o_result.body_valid !== e.body_valid) begin
                    $error("body_valid exp %0d got %0d", e.body_valid, o_result.body_valid);
                    mismatches++;
                end
                if (o_result.body_byte !== e.body_byte) begin
                    $error("body_byte exp %0h got %0h", e.body_byte, o_result.body_byte);
                    mismatches++;
                end
                if (o_result.status_valid !== e.status_valid) begin
                    $error("status_valid exp %0d got %0d", e.status_valid,
                           o_result.status_valid);
                    mismatches++;
                end
                if (o_result.resp_status !== e.resp_status) begin
                    $error("resp_status exp %0d got %0d", e.resp_status, o_result.resp_status);
                    mismatches++;
                end
                if (o_result.message_done !== e.message_done) begin
                    $error("message_done exp %0d got %0d", e.message_done,
                           o_result.message_done);
                    mismatches++;
                end
                if (o_result.parse_error !== e.parse_error) begin
                    $error("parse_error exp %0d got %0d", e.parse_error, o_result.parse_error);
                    mismatches++;
                end
                if (o_result.incomplete !== e.incomplete) begin
                    $error("incomplete exp %0d got %0d", e.incomplete, o_result.incomplete);
                    mismatches++;
                end
                if (o_result.consumed_count !== e.consumed_count) begin
                    $error("consumed_count exp %0d got %0d", e.consumed_count,
                           o_result.consumed_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #30_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        mismatches = 0; sent_total = 0; hold_off = 0;
        push = 0; pop = 0; i_item = '0;
        parser_clear();
        i_rst_n = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: chunked with trailer, upper-case hex
        send_text("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\nA\r\n0123456789\r\n"
                  , 1);
        send_text("0\r\nX: y\r\n\r\n");
        send_text("HTTP/1.0 65535 X\r\nContent-Length: 3\r\n\r\n\x01\xff\x80", 1);
        // status overflow, sign in code, missing colon, bad length, zero length, chunked and stray cr cases
        send_text("HTTP/1.1 65536\r\n", 1);
        send_text("HTTP/1.1 -1\r\n", 1);
        send_text("H 204\r\nBadHeader\r\n", 1);
        send_text("H 200\r\ncontent-length: x\r\n\r\n", 1);
        send_text("H 200\r\ncontent-length: 99999999999\r\n\r\n", 1);
        send_text("H 200\r\ncontent-length: 0\r\n\r\nzz", 1);
        send_text("H 200\r\ntransfer-encoding: chunky\r\n\r\n", 1);
        send_text("H 200\r\ntransfer-encoding:chunked\r\n\r\n1\r\nab", 1);
        send_text("H 200\r\ntransfer-encoding:chunked\r\n\r\nfffffffff\r\n", 1);
        send_text("H 200\r\na\rb\n:x\r\r\n\r\n", 1);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_off = 300;
        for (int k = 0; k < 2; k++) send_response();
        wait_drained();

        while (sent_total < 500) begin
            if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 20));
            else send_response();
            // occasionally let everything drain before going on
            if ($urandom_range(0, 15) == 0) wait_drained();
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
